// ----- hw/rtl/dpe_pkg.sv -----
`default_nettype none
package dpe_pkg;

  localparam int VTX_W        = 8;
  localparam int MAX_VERTICES = 1 << VTX_W;
  localparam int IDX_W        = VTX_W + 1;
  localparam int DEG_W        = 9;
  localparam logic [DEG_W-1:0] DEG_MAX = {DEG_W{1'b1}};

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_PEEL = 1'b1;

  typedef logic [MAX_VERTICES-1:0] row_t;

  // one shared read address and one shared write address for both memories
  typedef struct packed {
    logic             rd_en;
    logic [VTX_W-1:0] rd_addr;
    logic             adj_we;
    logic             deg_we;
    logic [VTX_W-1:0] wr_addr;
    row_t             adj_wdata;
    logic [DEG_W-1:0] deg_wdata;
  } store_req_t;

  function automatic row_t vtx_mask(input logic [VTX_W-1:0] v);
    row_t m;
    m = '0;
    m[v] = 1'b1;
    return m;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/dpe_in_if.sv -----
`default_nettype none
interface dpe_in_if import dpe_pkg::*;;
  logic             valid;
  logic             ready;
  logic             operation;
  logic [VTX_W-1:0] vertex_a;
  logic [VTX_W-1:0] vertex_b;

  modport source (output valid, operation, vertex_a, vertex_b, input ready);
  modport sink (input valid, operation, vertex_a, vertex_b, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/dpe_out_if.sv -----
`default_nettype none
interface dpe_out_if import dpe_pkg::*;;
  logic             valid;
  logic             ready;
  logic [VTX_W-1:0] vertex;
  logic [DEG_W-1:0] min_degree;
  logic             none_left;

  modport source (output valid, vertex, min_degree, none_left, input ready);
  modport sink (input valid, vertex, min_degree, none_left, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/dpe_store.sv -----
`default_nettype none
module dpe_store import dpe_pkg::*; (
  input  wire logic             clk,
  input  wire store_req_t       mem_req,
  output logic [MAX_VERTICES-1:0] adj_q,
  output logic [DEG_W-1:0]      deg_q
);

  logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
  logic [DEG_W-1:0]        deg_mem [MAX_VERTICES];

  always_ff @(posedge clk) begin
    if (mem_req.adj_we) begin
      adj_mem[mem_req.wr_addr] <= mem_req.adj_wdata;
    end
    if (mem_req.deg_we) begin
      deg_mem[mem_req.wr_addr] <= mem_req.deg_wdata;
    end
    if (mem_req.rd_en) begin
      adj_q <= adj_mem[mem_req.rd_addr];
      deg_q <= deg_mem[mem_req.rd_addr];
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/degeneracy_peel_engine.sv -----
// add edge: two reads then two writes
// peel: one degree read per cycle over the minimum scan; the result is offered after
// the scan, then one row and degree read-modify-write per cycle in the neighbor walk
// one item in flight at a time, a result not yet taken holds the peel before the walk
// synchronous active-high reset empties the graph through the present flags
`default_nettype none
module degeneracy_peel_engine import dpe_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  dpe_in_if.sink    item,
  dpe_out_if.source result
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ADD_RA = 4'd1;
  localparam logic [3:0] S_ADD_RB = 4'd2;
  localparam logic [3:0] S_ADD_WA = 4'd3;
  localparam logic [3:0] S_ADD_WB = 4'd4;
  localparam logic [3:0] S_SCAN   = 4'd5;
  localparam logic [3:0] S_EMIT   = 4'd6;
  localparam logic [3:0] S_ROW    = 4'd7;
  localparam logic [3:0] S_WALK   = 4'd8;

  logic [3:0]        state;
  logic [VTX_W-1:0]  va;
  logic [VTX_W-1:0]  vb;
  row_t              present;
  row_t              row_a;
  row_t              row_b;
  logic [DEG_W-1:0]  deg_a;
  logic [DEG_W-1:0]  deg_b;
  logic              new_edge;
  logic [IDX_W-1:0]  idx;
  logic              pend;
  logic [VTX_W-1:0]  pend_idx;
  logic              found;
  logic [VTX_W-1:0]  best;
  logic [DEG_W-1:0]  best_deg;

  logic              out_valid;
  logic [VTX_W-1:0]  out_vertex;
  logic [DEG_W-1:0]  out_degree;
  logic              out_none;

  store_req_t        mem_req;
  row_t              adj_q;
  logic [DEG_W-1:0]  deg_q;

  logic              out_free;
  logic              take;
  logic              walk_hit;

  dpe_store u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .adj_q   (adj_q),
    .deg_q   (deg_q)
  );

  assign item.ready        = (state == S_IDLE);
  assign take              = item.valid && item.ready;
  assign out_free          = !out_valid || result.ready;
  assign result.valid      = out_valid;
  assign result.vertex     = out_vertex;
  assign result.min_degree = out_degree;
  assign result.none_left  = out_none;

  assign walk_hit = pend && row_a[pend_idx] && (pend_idx != best);

  always_comb begin
    mem_req = '0;
    case (state)
      S_ADD_RA: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = va;
      end
      S_ADD_RB: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = vb;
      end
      S_ADD_WA: begin
        mem_req.wr_addr   = va;
        mem_req.adj_we    = !row_a[vb];
        mem_req.deg_we    = !row_a[vb];
        mem_req.adj_wdata = row_a | vtx_mask(vb);
        mem_req.deg_wdata = (deg_a == DEG_MAX) ? deg_a : DEG_W'(deg_a + 1'b1);
      end
      S_ADD_WB: begin
        // a self-loop was fully written in the previous cycle
        mem_req.wr_addr   = vb;
        mem_req.adj_we    = new_edge && (va != vb);
        mem_req.deg_we    = new_edge && (va != vb);
        mem_req.adj_wdata = row_b | vtx_mask(va);
        mem_req.deg_wdata = (deg_b == DEG_MAX) ? deg_b : DEG_W'(deg_b + 1'b1);
      end
      S_SCAN: begin
        mem_req.rd_en   = !idx[VTX_W];
        mem_req.rd_addr = idx[VTX_W-1:0];
      end
      S_EMIT: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = best;
      end
      S_WALK: begin
        mem_req.rd_en     = !idx[VTX_W];
        mem_req.rd_addr   = idx[VTX_W-1:0];
        mem_req.wr_addr   = pend_idx;
        mem_req.adj_we    = walk_hit;
        mem_req.adj_wdata = adj_q & ~vtx_mask(best);
        mem_req.deg_we    = walk_hit && present[pend_idx] && (deg_q != '0);
        mem_req.deg_wdata = DEG_W'(deg_q - 1'b1);
      end
      default: begin
        mem_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      present   <= '0;
      out_valid <= 1'b0;
      pend      <= 1'b0;
      found     <= 1'b0;
    end else begin
      // the emit state reloads the output register itself
      if (out_valid && result.ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            va <= item.vertex_a;
            vb <= item.vertex_b;
            if (item.operation == OP_ADD) begin
              state <= S_ADD_RA;
            end else begin
              idx   <= '0;
              pend  <= 1'b0;
              found <= 1'b0;
              state <= S_SCAN;
            end
          end
        end
        S_ADD_RA: begin
          state <= S_ADD_RB;
        end
        S_ADD_RB: begin
          // an absent vertex holds a stale row in memory, read it as empty
          row_a <= present[va] ? adj_q : '0;
          deg_a <= present[va] ? deg_q : '0;
          state <= S_ADD_WA;
        end
        S_ADD_WA: begin
          row_b    <= present[vb] ? adj_q : '0;
          deg_b    <= present[vb] ? deg_q : '0;
          new_edge <= !row_a[vb];
          state    <= S_ADD_WB;
        end
        S_ADD_WB: begin
          present <= present | vtx_mask(va) | vtx_mask(vb);
          state   <= S_IDLE;
        end
        S_SCAN: begin
          if (!idx[VTX_W]) begin
            idx <= IDX_W'(idx + 1'b1);
          end
          pend     <= !idx[VTX_W];
          pend_idx <= idx[VTX_W-1:0];
          if (pend && present[pend_idx] && (!found || deg_q < best_deg)) begin
            found    <= 1'b1;
            best     <= pend_idx;
            best_deg <= deg_q;
          end
          if (idx[VTX_W] && !pend) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_vertex <= found ? best : '0;
            out_degree <= found ? best_deg : '0;
            out_none   <= !found;
            state      <= found ? S_ROW : S_IDLE;
          end
        end
        S_ROW: begin
          row_a         <= adj_q;
          present[best] <= 1'b0;
          idx           <= '0;
          pend          <= 1'b0;
          state         <= S_WALK;
        end
        S_WALK: begin
          if (!idx[VTX_W]) begin
            idx <= IDX_W'(idx + 1'b1);
          end
          pend     <= !idx[VTX_W];
          pend_idx <= idx[VTX_W-1:0];
          if (idx[VTX_W] && !pend) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
